@@ rtl/breakpoint_address_map_core_macros.svh @@
// assertion macros for the breakpoint address map core
// depends on nothing; the using module supplies i_clk and i_rst_n
`ifndef BREAKPOINT_ADDRESS_MAP_CORE_MACROS_SVH
`define BREAKPOINT_ADDRESS_MAP_CORE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, disabled while reset is asserted
`define BAPM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bapm assertion failed");

// next-cycle implication, disabled while reset is asserted
`define BAPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bapm assertion failed");

`else

`define BAPM_ASSERT_IMPL(label, ante, cons)
`define BAPM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/bapm_pkg.sv @@
// shared types and constants of the breakpoint address map core
// request and result packing on the stream ports, operation codes
package bapm_pkg;

    localparam int FUNC_W    = 3;
    localparam int IN_ADDR_W = 16;
    localparam int IN_ID_W   = 8;

    // request tdata: func, address, bp_id from bit 0 up
    localparam int FUNC_LSB  = 0;
    localparam int ADDR_LSB  = FUNC_LSB + FUNC_W;
    localparam int ID_LSB    = ADDR_LSB + IN_ADDR_W;
    localparam int S_TDATA_W = 32;

    // result tdata: ok, found_id, found_address from bit 0 up
    localparam int OUT_ID_W   = 8;
    localparam int OUT_ADDR_W = 16;
    localparam int OK_LSB     = 0;
    localparam int FID_LSB    = OK_LSB + 1;
    localparam int FADDR_LSB  = FID_LSB + OUT_ID_W;
    localparam int M_TDATA_W  = 32;

    typedef enum logic [FUNC_W-1:0] {
        OP_ADD          = 3'd0,
        OP_CLEAR_MATCH  = 3'd1,
        OP_CLEAR_ADDR   = 3'd2,
        OP_CLEAR_ALL_ID = 3'd3,
        OP_FIND         = 3'd4,
        OP_LOOKUP       = 3'd5
    } t_func;

endpackage

@@ rtl/bapm_mem.sv @@
// entry memory of the breakpoint address map: one write port, one read port
// read data registered; depends on bapm_pkg
module bapm_mem
    import bapm_pkg::*;
#(
    parameter int AW = 16,
    parameter int DW = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/breakpoint_address_map_core.sv @@
// Breakpoint address map: one entry per address, each empty or holding a
// breakpoint id, kept in a single-port-write, single-port-read memory word of
// {valid, id}. After reset the block clears all 2**ADDR_BITS addresses
// (65536 by default) with o_s_tready low. Add, clear-if-match, clear-address
// and lookup each do one memory read, then the result and any write-back.
// Clear-all-by-id and find walk the memory one address per cycle on the read
// port: clear-all visits every address, find stops at the lowest matching
// address, or after the last address when nothing matches.
// The result sits in an output register, so the next request is taken while
// it waits; a request finishing while that register is still full waits one
// more state until it drains.
// depends on bapm_pkg, bapm_mem and breakpoint_address_map_core_macros.svh
`include "breakpoint_address_map_core_macros.svh"

module breakpoint_address_map_core
    import bapm_pkg::*;
#(
    parameter int ADDR_BITS = 16,
    parameter int ID_BITS   = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // func[2:0], address[18:3], bp_id[26:19], zero fill
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // ok[0], found_id[8:1], found_address[24:9], zero fill
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    localparam int EW = ID_BITS + 1;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_SCAN,
        ST_PUSH
    } t_state;

    t_state                r_state;
    t_func                 r_func;
    logic [ADDR_BITS-1:0]  r_addr;
    logic [ID_BITS-1:0]    r_id;
    logic                  r_hit;
    logic                  r_res_ok;
    logic [OUT_ID_W-1:0]   r_res_id;
    logic [OUT_ADDR_W-1:0] r_res_addr;
    logic                  r_out_valid;
    logic                  r_out_ok;
    logic [OUT_ID_W-1:0]   r_out_id;
    logic [OUT_ADDR_W-1:0] r_out_addr;

    logic [ADDR_BITS-1:0]  n_addr;
    logic                  n_hit;

    // request unpacking, fields folded to the configured widths
    t_func                          in_func;
    logic [IN_ADDR_W-1:0]           in_address;
    logic [IN_ID_W-1:0]             in_bp_id;
    logic [ADDR_BITS+IN_ADDR_W-1:0] in_addr_wide;
    logic [ID_BITS+IN_ID_W-1:0]     in_id_wide;
    logic [ADDR_BITS-1:0]           in_addr;
    logic [ID_BITS-1:0]             in_id;
    logic                           in_scan;

    assign in_func      = t_func'(i_s_tdata[FUNC_LSB +: FUNC_W]);
    assign in_address   = i_s_tdata[ADDR_LSB +: IN_ADDR_W];
    assign in_bp_id     = i_s_tdata[ID_LSB +: IN_ID_W];
    assign in_addr_wide = {{ADDR_BITS{1'b0}}, in_address};
    assign in_id_wide   = {{ID_BITS{1'b0}}, in_bp_id};
    assign in_addr      = in_addr_wide[ADDR_BITS-1:0];
    assign in_id        = in_id_wide[ID_BITS-1:0];
    assign in_scan      = (in_func == OP_CLEAR_ALL_ID) || (in_func == OP_FIND);

    // memory port
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic [EW-1:0]        mem_wdata;
    logic [ADDR_BITS-1:0] mem_raddr;
    logic [EW-1:0]        mem_rdata;

    bapm_mem #(
        .AW (ADDR_BITS),
        .DW (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    logic                      rd_valid;
    logic [ID_BITS-1:0]        rd_id;
    logic                      match;
    logic                      addr_last;
    logic [ID_BITS+OUT_ID_W-1:0]     rd_id_wide;
    logic [ADDR_BITS+OUT_ADDR_W-1:0] cur_addr_wide;

    assign rd_valid      = mem_rdata[ID_BITS];
    assign rd_id         = mem_rdata[ID_BITS-1:0];
    assign match         = rd_valid && (rd_id == r_id);
    assign addr_last     = &r_addr;
    assign rd_id_wide    = {{OUT_ID_W{1'b0}}, rd_id};
    assign cur_addr_wide = {{OUT_ADDR_W{1'b0}}, r_addr};

    logic s_accept;
    logic out_free;
    logic done;
    logic load_out;
    logic res_ok;
    logic [OUT_ID_W-1:0]   res_id;
    logic [OUT_ADDR_W-1:0] res_addr;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    // output register takes a finished or a waiting result
    assign load_out   = (done || (r_state == ST_PUSH)) && out_free;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        mem_raddr = r_addr;
        n_addr    = r_addr;
        n_hit     = r_hit;
        done      = 1'b0;
        res_ok    = 1'b0;
        res_id    = '0;
        res_addr  = '0;
        unique case (r_state)
            ST_CLR: begin
                mem_we = 1'b1;
                n_addr = r_addr + 1'b1;
            end
            ST_IDLE: begin
                mem_raddr = in_scan ? '0 : in_addr;
            end
            ST_RD: begin
                done = 1'b1;
                case (r_func)
                    OP_ADD: begin
                        if (rd_valid) begin
                            res_id = rd_id_wide[OUT_ID_W-1:0];
                        end else begin
                            mem_we    = 1'b1;
                            mem_wdata = {1'b1, r_id};
                            res_ok    = 1'b1;
                        end
                    end
                    OP_CLEAR_MATCH: begin
                        if (match) begin
                            mem_we = 1'b1;
                            res_ok = 1'b1;
                        end
                    end
                    OP_CLEAR_ADDR: begin
                        mem_we = 1'b1;
                    end
                    OP_LOOKUP: begin
                        if (rd_valid) begin
                            res_ok = 1'b1;
                            res_id = rd_id_wide[OUT_ID_W-1:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_SCAN: begin
                // data for r_addr is here; unless the scan ends, the read of the next address goes out now
                if (r_func == OP_FIND) begin
                    if (match) begin
                        done     = 1'b1;
                        res_ok   = 1'b1;
                        res_addr = cur_addr_wide[OUT_ADDR_W-1:0];
                    end else if (addr_last) begin
                        done = 1'b1;
                    end else begin
                        n_addr    = r_addr + 1'b1;
                        mem_raddr = n_addr;
                    end
                end else begin
                    if (match) begin
                        mem_we = 1'b1;
                        n_hit  = 1'b1;
                    end
                    if (addr_last) begin
                        done   = 1'b1;
                        res_ok = r_hit || match;
                    end else begin
                        n_addr    = r_addr + 1'b1;
                        mem_raddr = n_addr;
                    end
                end
            end
            ST_PUSH: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_addr      <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLR: begin
                    r_addr <= n_addr;
                    if (addr_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_accept) begin
                        r_func  <= in_func;
                        r_addr  <= in_scan ? '0 : in_addr;
                        r_id    <= in_id;
                        r_hit   <= 1'b0;
                        r_state <= in_scan ? ST_SCAN : ST_RD;
                    end
                end
                ST_RD, ST_SCAN: begin
                    r_addr <= n_addr;
                    r_hit  <= n_hit;
                    if (done) begin
                        if (out_free) begin
                            r_out_ok    <= res_ok;
                            r_out_id    <= res_id;
                            r_out_addr  <= res_addr;
                            r_state     <= ST_IDLE;
                        end else begin
                            r_res_ok   <= res_ok;
                            r_res_id   <= res_id;
                            r_res_addr <= res_addr;
                            r_state    <= ST_PUSH;
                        end
                    end
                end
                ST_PUSH: begin
                    if (out_free) begin
                        r_out_ok    <= r_res_ok;
                        r_out_id    <= r_res_id;
                        r_out_addr  <= r_res_addr;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W - FADDR_LSB - OUT_ADDR_W){1'b0}},
                         r_out_addr, r_out_id, r_out_ok};

    // no request taken while the memory is still being cleared
    `BAPM_ASSERT_IMPL(a_no_accept_in_clear, r_state == ST_CLR, !o_s_tready)
    // a waiting result only exists while the output register is occupied
    `BAPM_ASSERT_IMPL(a_push_has_output, r_state == ST_PUSH, r_out_valid)
    // the memory is never written while waiting for a request
    `BAPM_ASSERT_IMPL(a_idle_no_write, r_state == ST_IDLE, !mem_we)
    // a reported address always comes with ok
    `BAPM_ASSERT_IMPL(a_addr_implies_ok, r_out_valid && (r_out_addr != '0), r_out_ok)
    // a taken request always leads to a memory access state
    `BAPM_ASSERT_NEXT(a_accept_starts_op, s_accept, r_state == ST_RD || r_state == ST_SCAN)

endmodule
